// ===== rtl/vdcf_pkg.sv =====
// ----------------------------------------------------------------------------
// vdcf_pkg
// Shared sizes, types and the threshold reset value for the deadband change filter.
// ----------------------------------------------------------------------------
package vdcf_pkg;

   localparam int GROUPS     = 3;
   localparam int LANES      = 7;
   localparam int JOINT_W    = 24;
   localparam int SQ_W       = 2 * JOINT_W;
   localparam int SUM_W      = 48;
   localparam int TREE_W     = SQ_W + $clog2(LANES + 1);
   localparam int CNT_W      = 16;
   localparam int IDX_W      = 2;
   localparam int GSEL_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int PEND_N     = (GROUPS > 1) ? GROUPS - 1 : 1;
   localparam int PSEL_W     = (PEND_N > 1) ? $clog2(PEND_N) : 1;
   localparam int REQ_DATA_W = ((LANES * JOINT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((LANES * JOINT_W + 2 * CNT_W + 7) / 8) * 8;
   localparam int RSP_USER_W = IDX_W + 1;

   localparam logic [SUM_W-1:0] THRESH_RESET = SUM_W'(9895604);

   typedef logic [SQ_W-1:0]                              sq_type;
   typedef logic [LANES-1:0][JOINT_W-1:0]                group_type;
   typedef logic [GROUPS-1:0][LANES-1:0][JOINT_W-1:0]    vector_type;
   typedef logic [PEND_N-1:0][LANES-1:0][JOINT_W-1:0]    pending_type;
   typedef logic [LANES-1:0][SQ_W-1:0]                   sq_group_type;

   typedef struct packed {
      logic             keep;
      logic [CNT_W-1:0] kept_count;
      logic [CNT_W-1:0] seen_count;
   } result_type;

endpackage

// ===== rtl/vdcf_lane.sv =====
// ----------------------------------------------------------------------------
// vdcf_lane
// One joint lane: difference against the reference, squared and registered.
// ----------------------------------------------------------------------------
module vdcf_lane (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [vdcf_pkg::JOINT_W-1:0] cur_joint,
   input  logic signed [vdcf_pkg::JOINT_W-1:0] ref_joint,
   output logic        [vdcf_pkg::SQ_W-1:0]    sq_ff,
   output logic        [vdcf_pkg::JOINT_W-1:0] cur_ff
);

   logic signed [vdcf_pkg::JOINT_W:0]   diff;
   logic        [vdcf_pkg::JOINT_W-1:0] mag;
   logic        [vdcf_pkg::SQ_W-1:0]    sq_in;

   always_comb begin
      diff  = {cur_joint[vdcf_pkg::JOINT_W-1], cur_joint}
            - {ref_joint[vdcf_pkg::JOINT_W-1], ref_joint};
      mag   = diff[vdcf_pkg::JOINT_W] ? vdcf_pkg::JOINT_W'(-diff)
                                      : diff[vdcf_pkg::JOINT_W-1:0];
      sq_in = mag * mag;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff  <= sq_in;
         cur_ff <= cur_joint;
      end
   end

endmodule

// ===== rtl/vdcf_merge.sv =====
// ----------------------------------------------------------------------------
// vdcf_merge
// Lane merge: sums the lane squares, adds the running sum unless restart is set,
// saturates and compares against the threshold.
// ----------------------------------------------------------------------------
module vdcf_merge (
   input  vdcf_pkg::sq_group_type      lane_sq,
   input  logic [vdcf_pkg::SUM_W-1:0]  partial,
   input  logic                        restart,
   input  logic [vdcf_pkg::SUM_W-1:0]  threshold,
   output logic [vdcf_pkg::SUM_W-1:0]  sum,
   output logic                        keep
);

   logic [vdcf_pkg::TREE_W-1:0] tree;
   logic [vdcf_pkg::TREE_W:0]   total;

   always_comb begin
      tree = '0;
      for (int l = 0; l < vdcf_pkg::LANES; l++) begin
         tree = tree + vdcf_pkg::TREE_W'(lane_sq[l]);
      end
      total = (vdcf_pkg::TREE_W + 1)'(tree)
            + (restart ? '0 : (vdcf_pkg::TREE_W + 1)'(partial));
      if (total > (vdcf_pkg::TREE_W + 1)'({vdcf_pkg::SUM_W{1'b1}})) begin
         sum = '1;
      end else begin
         sum = total[vdcf_pkg::SUM_W-1:0];
      end
      keep = sum > threshold;
   end

endmodule

// ===== rtl/vdcf_emit.sv =====
// ----------------------------------------------------------------------------
// vdcf_emit
// Result sequencer: sends a kept vector as one word per group, or a single
// dropped word, and holds while the receiver stalls.
// ----------------------------------------------------------------------------
module vdcf_emit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  vdcf_pkg::result_type                 result,
   input  vdcf_pkg::vector_type                 ref_vector,
   output logic                                 free,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // joint0..joint(LANES-1), kept_count, seen_count, zero fill
   output logic [vdcf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // kept, out_robot
   output logic [vdcf_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);

   logic                         active_ff, active_in;
   logic                         kept_ff, kept_in;
   logic [vdcf_pkg::GSEL_W-1:0]  grp_ff, grp_in;
   logic [vdcf_pkg::CNT_W-1:0]   kcnt_ff, kcnt_in;
   logic [vdcf_pkg::CNT_W-1:0]   scnt_ff, scnt_in;
   logic                         last_word;
   logic                         done;

   always_comb begin
      last_word = !kept_ff || (grp_ff == vdcf_pkg::GSEL_W'(vdcf_pkg::GROUPS - 1));
      done      = active_ff && rsp_tready && last_word;
      free      = !active_ff || done;

      active_in = active_ff;
      kept_in   = kept_ff;
      grp_in    = grp_ff;
      kcnt_in   = kcnt_ff;
      scnt_in   = scnt_ff;
      if (load) begin
         active_in = 1'b1;
         kept_in   = result.keep;
         grp_in    = '0;
         kcnt_in   = result.kept_count;
         scnt_in   = result.seen_count;
      end else if (active_ff && rsp_tready) begin
         if (last_word) begin
            active_in = 1'b0;
         end else begin
            grp_in = grp_ff + vdcf_pkg::GSEL_W'(1);
         end
      end

      rsp_tvalid = active_ff;
      rsp_tlast  = last_word;
      rsp_tuser  = {(kept_ff ? vdcf_pkg::IDX_W'(grp_ff) : vdcf_pkg::IDX_W'(0)), kept_ff};
      rsp_tdata  = '0;
      for (int l = 0; l < vdcf_pkg::LANES; l++) begin
         rsp_tdata[l*vdcf_pkg::JOINT_W +: vdcf_pkg::JOINT_W] =
            kept_ff ? ref_vector[grp_ff][l] : '0;
      end
      rsp_tdata[vdcf_pkg::LANES*vdcf_pkg::JOINT_W +: vdcf_pkg::CNT_W] = kcnt_ff;
      rsp_tdata[vdcf_pkg::LANES*vdcf_pkg::JOINT_W + vdcf_pkg::CNT_W +: vdcf_pkg::CNT_W] =
         scnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      kept_ff <= kept_in;
      grp_ff  <= grp_in;
      kcnt_ff <= kcnt_in;
      scnt_ff <= scnt_in;
   end

endmodule

// ===== rtl/vector_deadband_change_filter_core.sv =====
// ----------------------------------------------------------------------------
// vector_deadband_change_filter_core
// Deadband change filter for multi-robot joint vectors.
//
// Input words carry the joints of one robot group, the group index on
// req_tuser. Each group is squared against the reference vector in seven
// parallel lanes, one registered multiplier per lane; the merge stage sums
// the lanes into the running sum. The word for the last group completes the
// vector: above the threshold it is kept, becomes the reference and leaves
// as one rsp word per group; otherwise a single dropped word leaves.
// The completing input word is registered in the lane stage and then loads the
// result sequencer, whose register makes the first result word valid once the
// result side is free. Throughput: one input word per cycle, except that
// req_tready is low while a completing word sits in the lane stage, so the
// reference settles before the next vector. A group index out of range is taken and
// dropped. The threshold is written through csr_wr_en/csr_wr_data.
// Reset clears the reference, sum, counters and threshold default; no clear
// pass is needed. When rsp_tready is low, results hold and, once the
// lane stage holds a completing word, req_tready drops.
// ----------------------------------------------------------------------------
module vector_deadband_change_filter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [vdcf_pkg::SUM_W-1:0]          csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // joint0..joint(LANES-1), zero fill
   input  logic [vdcf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // robot_index
   input  logic [vdcf_pkg::IDX_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // joint0..joint(LANES-1), kept_count, seen_count, zero fill
   output logic [vdcf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // kept, out_robot
   output logic [vdcf_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);

   logic [vdcf_pkg::SUM_W-1:0]  thresh_ff, thresh_in;
   vdcf_pkg::vector_type        ref_ff, ref_in;
   vdcf_pkg::pending_type       pending_ff, pending_in;
   logic [vdcf_pkg::SUM_W-1:0]  partial_ff, partial_in;
   logic [vdcf_pkg::CNT_W-1:0]  seen_ff, seen_in;
   logic [vdcf_pkg::CNT_W-1:0]  kept_ff, kept_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic [vdcf_pkg::GSEL_W-1:0] s1_grp_ff, s1_grp_in;

   logic [vdcf_pkg::GSEL_W-1:0] req_grp;
   logic                        in_range;
   logic                        accept;
   logic                        lane_load;
   logic                        complete;
   logic                        s2_fire;
   logic                        emit_free;
   logic                        emit_load;
   vdcf_pkg::result_type        result;
   vdcf_pkg::sq_group_type      lane_sq;
   vdcf_pkg::group_type         lane_cur;
   logic [vdcf_pkg::SUM_W-1:0]  sum;
   logic                        keep;

   assign req_grp   = vdcf_pkg::GSEL_W'(req_tuser);
   assign in_range  = 32'(req_tuser) < vdcf_pkg::GROUPS;
   assign complete  = s1_grp_ff == vdcf_pkg::GSEL_W'(vdcf_pkg::GROUPS - 1);
   assign s2_fire   = s1_valid_ff && (!complete || emit_free);
   assign req_tready = !s1_valid_ff || (s2_fire && !complete);
   assign accept    = req_tvalid && req_tready;
   assign lane_load = accept && in_range;
   assign emit_load = s2_fire && complete;

   for (genvar l = 0; l < vdcf_pkg::LANES; l++) begin : g_lane
      vdcf_lane u_lane (
         .clock     (clock),
         .load      (lane_load),
         .cur_joint (req_tdata[l*vdcf_pkg::JOINT_W +: vdcf_pkg::JOINT_W]),
         .ref_joint (ref_ff[req_grp][l]),
         .sq_ff     (lane_sq[l]),
         .cur_ff    (lane_cur[l])
      );
   end

   vdcf_merge u_merge (
      .lane_sq   (lane_sq),
      .partial   (partial_ff),
      .restart   (s1_grp_ff == '0),
      .threshold (thresh_ff),
      .sum       (sum),
      .keep      (keep)
   );

   always_comb begin
      thresh_in   = csr_wr_en ? csr_wr_data : thresh_ff;
      ref_in      = ref_ff;
      pending_in  = pending_ff;
      partial_in  = partial_ff;
      seen_in     = seen_ff;
      kept_in     = kept_ff;

      s1_valid_in = s1_valid_ff;
      s1_grp_in   = s1_grp_ff;
      if (lane_load) begin
         s1_valid_in = 1'b1;
         s1_grp_in   = req_grp;
      end else if (s2_fire) begin
         s1_valid_in = 1'b0;
      end

      if (s2_fire) begin
         if (!complete) begin
            pending_in[s1_grp_ff[vdcf_pkg::PSEL_W-1:0]] = lane_cur;
            partial_in = sum;
         end else begin
            partial_in = '0;
            if (seen_ff != '1) begin
               seen_in = seen_ff + vdcf_pkg::CNT_W'(1);
            end
            if (keep) begin
               if (kept_ff != '1) begin
                  kept_in = kept_ff + vdcf_pkg::CNT_W'(1);
               end
               for (int g = 0; g < vdcf_pkg::GROUPS - 1; g++) begin
                  ref_in[g] = pending_ff[g];
               end
               ref_in[vdcf_pkg::GROUPS-1] = lane_cur;
            end
         end
      end

      result.keep       = keep;
      result.kept_count = kept_in;
      result.seen_count = seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= vdcf_pkg::THRESH_RESET;
         ref_ff      <= '0;
         partial_ff  <= '0;
         seen_ff     <= '0;
         kept_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         thresh_ff   <= thresh_in;
         ref_ff      <= ref_in;
         partial_ff  <= partial_in;
         seen_ff     <= seen_in;
         kept_ff     <= kept_in;
         s1_valid_ff <= s1_valid_in;
      end
      pending_ff <= pending_in;
      s1_grp_ff  <= s1_grp_in;
   end

   vdcf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (emit_load),
      .result     (result),
      .ref_vector (ref_ff),
      .free       (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/vector_deadband_change_filter_core_tb.sv =====
// ----------------------------------------------------------------------------
// vector_deadband_change_filter_core_tb
// Self-checking bench for the joint-vector deadband change filter.
//
// Drives robot groups on the req stream and predicts every rsp word from a
// software copy of the reference vector, the running sum of squares and the
// counters. Directed vectors cover zero motion, full-scale swings, sum
// saturation, strict threshold compare, ignored indexes and group restarts.
// Random phases follow under several thresholds. One phase runs without
// idling. Both stream sides idle at
// random, and a scoreboard checks each rsp word against the oldest
// expected word.
// ----------------------------------------------------------------------------
module vector_deadband_change_filter_core_tb;

   localparam int          LIMIT  = 2_000_000;
   localparam int          SETTLE = 8;
   localparam int          IDLE_PCT = 34;
   localparam logic [63:0] MAX48  = 64'hFFFF_FFFF_FFFF;
   localparam int          JBITS  = vdcf_pkg::LANES * vdcf_pkg::JOINT_W;

   typedef struct packed {
      logic                       kept;
      logic [1:0]                 robot;
      vdcf_pkg::group_type        joints;
      logic                       last;
      logic [vdcf_pkg::CNT_W-1:0] kept_count;
      logic [vdcf_pkg::CNT_W-1:0] seen_count;
   } filter_word_type;

   class deadband_scoreboard;
      logic [vdcf_pkg::SUM_W-1:0] threshold;
      vdcf_pkg::group_type        reference [vdcf_pkg::GROUPS];
      vdcf_pkg::group_type        pending [vdcf_pkg::GROUPS];
      logic [63:0]                running_sum;
      logic [vdcf_pkg::CNT_W-1:0] kept_total;
      logic [vdcf_pkg::CNT_W-1:0] seen_total;
      filter_word_type            expected_q [$];
      int                         mismatches;

      function new();
         threshold   = vdcf_pkg::THRESH_RESET;
         running_sum = 0;
         kept_total  = 0;
         seen_total  = 0;
         mismatches  = 0;
         for (int g = 0; g < vdcf_pkg::GROUPS; g++) begin
            reference[g] = '0;
            pending[g]   = '0;
         end
      endfunction

      function void note_input(logic [vdcf_pkg::IDX_W-1:0] idx, vdcf_pkg::group_type j);
         logic [63:0]        item_sum;
         logic [63:0]        total;
         logic signed [24:0] d;
         logic [24:0]        mag;
         filter_word_type    w;
         if (idx >= vdcf_pkg::GROUPS) return;
         item_sum = 0;
         for (int l = 0; l < vdcf_pkg::LANES; l++) begin
            d = $signed({j[l][vdcf_pkg::JOINT_W-1], j[l]}) -
                $signed({reference[idx][l][vdcf_pkg::JOINT_W-1], reference[idx][l]});
            mag = d[24] ? -d : d;
            item_sum += 64'(mag) * 64'(mag);
         end
         total = (idx == 0 ? 64'd0 : running_sum) + item_sum;
         if (total > MAX48) total = MAX48;
         if (idx != vdcf_pkg::GROUPS - 1) begin
            pending[idx] = j;
            running_sum  = total;
            return;
         end
         running_sum = 0;
         if (seen_total != '1) seen_total++;
         if (total > 64'(threshold)) begin
            if (kept_total != '1) kept_total++;
            for (int g = 0; g < vdcf_pkg::GROUPS - 1; g++) reference[g] = pending[g];
            reference[vdcf_pkg::GROUPS-1] = j;
            for (int g = 0; g < vdcf_pkg::GROUPS; g++) begin
               w.kept       = 1'b1;
               w.robot      = 2'(g);
               w.joints     = reference[g];
               w.last       = (g == vdcf_pkg::GROUPS - 1);
               w.kept_count = kept_total;
               w.seen_count = seen_total;
               expected_q.insert(expected_q.size(), w);
            end
         end else begin
            w.kept       = 1'b0;
            w.robot      = '0;
            w.joints     = '0;
            w.last       = 1'b1;
            w.kept_count = kept_total;
            w.seen_count = seen_total;
            expected_q.insert(expected_q.size(), w);
         end
      endfunction

      function void check_result(filter_word_type got);
         filter_word_type w;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp word: kept %0d robot %0d last %0d joints %h",
                        got.kept, got.robot, got.last, got.joints);
            return;
         end
         w = expected_q.pop_front();
         if (got !== w) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("rsp mismatch (exp/got): kept %0d/%0d robot %0d/%0d last %0d/%0d",
                        w.kept, got.kept, w.robot, got.robot, w.last, got.last);
               $display("   kept_count %0d/%0d seen_count %0d/%0d",
                        w.kept_count, got.kept_count, w.seen_count, got.seen_count);
               $display("   joints exp %h", w.joints);
               $display("   joints got %h", got.joints);
            end
         end
      endfunction
   endclass

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            csr_wr_en   = 1'b0;
   logic [vdcf_pkg::SUM_W-1:0]      csr_wr_data = '0;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [vdcf_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic [vdcf_pkg::IDX_W-1:0]      req_tuser   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [vdcf_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [vdcf_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                            rsp_tlast;

   bit                 idle_on = 1'b1;
   int                 cycle_count;
   deadband_scoreboard sb = new();

   vector_deadband_change_filter_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin : rsp_monitor
      filter_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kept       = rsp_tuser[0];
         got.robot      = rsp_tuser[2:1];
         got.joints     = rsp_tdata[JBITS-1:0];
         got.last       = rsp_tlast;
         got.kept_count = rsp_tdata[JBITS +: vdcf_pkg::CNT_W];
         got.seen_count = rsp_tdata[JBITS+vdcf_pkg::CNT_W +: vdcf_pkg::CNT_W];
         sb.check_result(got);
      end
   end

   function automatic vdcf_pkg::group_type fill(logic [vdcf_pkg::JOINT_W-1:0] v);
      vdcf_pkg::group_type j;
      for (int l = 0; l < vdcf_pkg::LANES; l++) j[l] = v;
      return j;
   endfunction

   // near the reference, full random, or full-scale corners
   function automatic vdcf_pkg::group_type make_group(int g);
      vdcf_pkg::group_type j;
      int                  pick;
      int                  delta;
      j    = sb.reference[g];
      pick = $urandom_range(99);
      for (int l = 0; l < vdcf_pkg::LANES; l++) begin
         if (pick < 50) begin
            delta = $urandom_range(1) ? int'($urandom_range(4000)) - 2000 : 0;
            j[l]  = j[l] + vdcf_pkg::JOINT_W'(delta);
         end else if (pick < 85) begin
            j[l] = vdcf_pkg::JOINT_W'($urandom);
         end else begin
            case ($urandom_range(3))
               0:       j[l] = 24'h7FFFFF;
               1:       j[l] = 24'h800000;
               2:       j[l] = 24'h000000;
               default: j[l] = 24'hFFFFFF;
            endcase
         end
      end
      return j;
   endfunction

   task automatic send_word(input logic [vdcf_pkg::IDX_W-1:0] idx,
                            input vdcf_pkg::group_type j);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= vdcf_pkg::REQ_DATA_W'(j);
      req_tuser  <= idx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(idx, j);
   endtask

   task automatic send_vector(input vdcf_pkg::group_type j0, input vdcf_pkg::group_type j1,
                              input vdcf_pkg::group_type j2);
      send_word(2'd0, j0);
      send_word(2'd1, j1);
      send_word(2'd2, j2);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [vdcf_pkg::SUM_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.threshold = v;
   endtask

   // mostly whole vectors in order; the rest single words of any index
   task automatic run_random(input int quota);
      int                         count;
      logic [vdcf_pkg::IDX_W-1:0] idx;
      count = 0;
      while (count < quota) begin
         if ($urandom_range(99) < 75) begin
            for (int g = 0; g < vdcf_pkg::GROUPS; g++)
               send_word(vdcf_pkg::IDX_W'(g), make_group(g));
            count += vdcf_pkg::GROUPS;
         end else begin
            idx = vdcf_pkg::IDX_W'($urandom_range(3));
            send_word(idx, make_group(idx < vdcf_pkg::GROUPS ? int'(idx) : 0));
            if (idx < vdcf_pkg::GROUPS) count++;
         end
      end
   endtask

   initial begin : stimulus
      vdcf_pkg::group_type z;
      vdcf_pkg::group_type z2;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero motion drops, ignored index, full-scale swings keep
      send_vector(fill(24'h0), fill(24'h0), fill(24'h0));
      send_word(2'd3, fill(24'hFFFFFF));
      send_vector(fill(24'h7FFFFF), fill(24'h7FFFFF), fill(24'h7FFFFF));
      send_vector(fill(24'h800000), fill(24'h800000), fill(24'h800000));

      // saturated sum against the top threshold drops
      write_threshold('1);
      send_vector(fill(24'h7FFFFF), fill(24'h7FFFFF), fill(24'h7FFFFF));

      // restart on group zero, lone last group, strict compare at zero
      write_threshold('0);
      send_word(2'd1, make_group(1));
      send_word(2'd0, make_group(0));
      z = make_group(2);
      send_word(2'd2, z);
      send_word(2'd2, z);
      z2 = z;
      z2[3] = z2[3] + 24'd1;
      send_word(2'd2, z2);

      write_threshold(vdcf_pkg::THRESH_RESET);
      run_random(40);
      write_threshold('0);
      run_random(40);
      drain();
      idle_on = 1'b0;
      run_random(40);
      idle_on = 1'b1;
      write_threshold('1);
      run_random(30);
      write_threshold(vdcf_pkg::SUM_W'({$urandom, $urandom}));
      run_random(40);
      write_threshold(vdcf_pkg::SUM_W'($urandom_range(200_000_000)));
      run_random(40);

      write_threshold(vdcf_pkg::THRESH_RESET);
      run_random(20);

      drain();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
